// ----- rtl/lisk_pkg.sv -----
// lisk_pkg: shared constants, datapath operation codes and the
// controller/datapath command and status types for the string kernel
// no dependencies
package lisk_pkg;

  localparam int DEF_MAX_HALF_WINDOW = 8;
  localparam int DEF_MAX_STRING_LEN  = 4096;
  localparam int DEF_FRAC_BITS       = 30;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 13;

  localparam logic [CFG_INDEX_W-1:0] REG_HALF_WINDOW = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MATCH_EXP   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SUM_EXP     = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_STRING_LEN  = 2'd3;

  localparam logic [3:0]  RST_HALF_WINDOW = 4'd3;
  localparam logic [2:0]  RST_MATCH_EXP   = 3'd1 + 3'd2;
  localparam logic [2:0]  RST_SUM_EXP     = 3'd1;
  localparam logic [12:0] RST_STRING_LEN  = 13'd4096;

  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NONE  = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD  = 4'd1;
  localparam logic [OP_W-1:0] OP_IPOW  = 4'd2;
  localparam logic [OP_W-1:0] OP_WMUL  = 4'd3;
  localparam logic [OP_W-1:0] OP_ADD   = 4'd4;
  localparam logic [OP_W-1:0] OP_DINIT = 4'd5;
  localparam logic [OP_W-1:0] OP_DPOW  = 4'd6;
  localparam logic [OP_W-1:0] OP_DN    = 4'd7;
  localparam logic [OP_W-1:0] OP_DW    = 4'd8;
  localparam logic [OP_W-1:0] OP_DIVI  = 4'd9;
  localparam logic [OP_W-1:0] OP_DIV   = 4'd10;
  localparam logic [OP_W-1:0] OP_OINIT = 4'd11;
  localparam logic [OP_W-1:0] OP_OPOW  = 4'd12;
  localparam logic [OP_W-1:0] OP_OUT   = 4'd13;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic       last;
    logic       too_short;
    logic       slot_free;
    logic [2:0] match_exp;
    logic [2:0] sum_exp;
  } status_t;

endpackage

// ----- rtl/lisk_datapath.sv -----
// lisk_datapath: configuration registers, match window, weighted
// accumulator, saturating multipliers, divider and output register
// depends on lisk_pkg
module lisk_datapath #(
  parameter int MAX_HALF_WINDOW = lisk_pkg::DEF_MAX_HALF_WINDOW,
  parameter int MAX_STRING_LEN  = lisk_pkg::DEF_MAX_STRING_LEN,
  parameter int FRAC_BITS       = lisk_pkg::DEF_FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [lisk_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lisk_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [7:0]                       char_a,
  input  logic [7:0]                       char_b,
  input  lisk_pkg::cmd_t                   cmd,
  output lisk_pkg::status_t                status,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [31:0]                      kernel_value,
  output logic                             length_error
);
  import lisk_pkg::*;

  localparam int HIST_W = 2 * MAX_HALF_WINDOW - 1;
  localparam int CNT_W  = $clog2(HIST_W + 1);
  localparam int LEN_W  = $clog2(MAX_STRING_LEN + 1);
  localparam int FB2    = FRAC_BITS + 2;
  localparam int IB     = (FB2 < 32) ? 32 - FB2 : 0;
  localparam int QW     = IB + FB2;
  localparam int PRW    = 64 + LEN_W;

  logic [3:0]  half_window;
  logic [2:0]  match_exp;
  logic [2:0]  sum_exp;
  logic [12:0] string_len;

  logic [HIST_W-1:0] history;
  logic [CNT_W-1:0]  cnt;
  logic [LEN_W-1:0]  pos;
  logic [LEN_W-1:0]  wt;
  logic              inw;
  logic              last;
  logic [63:0]       acc;
  logic [63:0]       term;
  logic [63:0]       rem;
  logic [63:0]       dvd;
  logic [QW-1:0]     q;
  logic              ovf;
  logic [31:0]       v;
  logic [31:0]       pw;

  int                h_i;
  int                n_i;
  logic [CNT_W-1:0]  p;
  logic [LEN_W-1:0]  n;
  logic [LEN_W-1:0]  w;
  logic              too_short;

  always_comb begin
    h_i = int'(half_window);
    if (h_i < 1) h_i = 1;
    if (h_i > MAX_HALF_WINDOW) h_i = MAX_HALF_WINDOW;
    n_i = int'(string_len);
    if (n_i < 1) n_i = 1;
    if (n_i > MAX_STRING_LEN) n_i = MAX_STRING_LEN;
    p = CNT_W'(2 * h_i - 1);
    n = LEN_W'(n_i);
  end

  assign too_short = n < LEN_W'(p);
  assign w = n - LEN_W'(p) + LEN_W'(1);

  // window update for a new pair
  logic [HIST_W-1:0] hist_new;
  logic [CNT_W-1:0]  cnt_new;
  logic [LEN_W-1:0]  seen;
  logic [LEN_W-1:0]  idx;
  logic              in_win;
  logic [LEN_W-1:0]  wt_new;

  always_comb begin
    hist_new = (history << 1) | HIST_W'(char_a == char_b);
    cnt_new = '0;
    for (int j = 0; j < HIST_W; j++) begin
      if (j < int'(p)) cnt_new = cnt_new + CNT_W'(hist_new[j]);
    end
    seen = pos + LEN_W'(1);
    idx = seen - LEN_W'(p);
    in_win = (seen >= LEN_W'(p)) && !too_short && (idx < w);
    wt_new = (idx < (w >> 1)) ? idx + LEN_W'(1) : w - idx;
  end

  // term multiplier saturating to 64 bits, and the power multiplier
  logic [LEN_W-1:0] mul_b;
  logic [PRW-1:0]   prod;
  logic [63:0]      sat64;
  logic [63:0]      pw_prod;
  logic [63:0]      pw_sh;

  always_comb begin
    case (cmd.op)
      OP_IPOW: mul_b = LEN_W'(cnt);
      OP_WMUL: mul_b = wt;
      OP_DPOW: mul_b = LEN_W'(p);
      OP_DN:   mul_b = n;
      OP_DW:   mul_b = w;
      default: mul_b = '0;
    endcase
    prod = PRW'(term) * PRW'(mul_b);
    sat64 = (prod[PRW-1:64] != '0) ? '1 : prod[63:0];
    pw_prod = 64'(pw) * 64'(v);
    pw_sh = pw_prod >> FRAC_BITS;
  end

  logic [64:0] sum;
  logic [64:0] r2;
  logic        ge;

  assign sum = {1'b0, acc} + {1'b0, term};
  assign r2  = {rem, dvd[63]};
  assign ge  = r2 >= {1'b0, term};

  always_ff @(posedge clk) begin
    if (rst) begin
      half_window <= RST_HALF_WINDOW;
      match_exp   <= RST_MATCH_EXP;
      sum_exp     <= RST_SUM_EXP;
      string_len  <= RST_STRING_LEN;
      history     <= '0;
      pos         <= '0;
      acc         <= '0;
      last        <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_HALF_WINDOW: half_window <= cfg_data[3:0];
          REG_MATCH_EXP:   match_exp   <= cfg_data[2:0];
          REG_SUM_EXP:     sum_exp     <= cfg_data[2:0];
          REG_STRING_LEN:  string_len  <= cfg_data[12:0];
          default: ;
        endcase
      end
      if (cmd.op == OP_OUT) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      case (cmd.op)
        OP_LOAD: begin
          history <= hist_new;
          pos     <= (seen >= n) ? '0 : seen;
          last    <= seen >= n;
        end
        OP_ADD: begin
          if (inw) acc <= sum[64] ? '1 : sum[63:0];
        end
        OP_OUT: begin
          history <= '0;
          pos     <= '0;
          acc     <= '0;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        cnt  <= cnt_new;
        wt   <= wt_new;
        inw  <= in_win;
        term <= 64'd1;
      end
      OP_IPOW, OP_WMUL, OP_DPOW, OP_DN, OP_DW: term <= sat64;
      OP_DINIT: term <= 64'd1;
      OP_DIVI: begin
        rem <= acc >> IB;
        dvd <= acc << (64 - IB);
        ovf <= (acc >> IB) >= term;
        q   <= '0;
      end
      OP_DIV: begin
        rem <= ge ? 64'(r2 - {1'b0, term}) : r2[63:0];
        dvd <= dvd << 1;
        q   <= {q[QW-2:0], ge};
      end
      OP_OINIT: begin
        v  <= (ovf || (q >> 32) != '0) ? '1 : q[31:0];
        pw <= (FRAC_BITS >= 32) ? '1 : 32'(64'd1 << FRAC_BITS);
      end
      OP_OPOW: pw <= (pw_sh > 64'hFFFF_FFFF) ? '1 : pw_sh[31:0];
      OP_OUT: begin
        kernel_value <= too_short ? '0 : pw;
        length_error <= too_short;
      end
      default: ;
    endcase
  end

  assign status.last      = last;
  assign status.too_short = too_short;
  assign status.slot_free = !out_valid || out_ready;
  assign status.match_exp = match_exp;
  assign status.sum_exp   = sum_exp;

endmodule

// ----- rtl/lisk_ctrl.sv -----
// lisk_ctrl: sequencing state machine for the string kernel datapath
// depends on lisk_pkg
module lisk_ctrl #(
  parameter int FRAC_BITS = lisk_pkg::DEF_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lisk_pkg::status_t status,
  output lisk_pkg::cmd_t    cmd
);
  import lisk_pkg::*;

  localparam int FB2   = FRAC_BITS + 2;
  localparam int STEPS = (FB2 < 32) ? 32 : FB2;
  localparam int KW    = $clog2(STEPS + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_IPOW  = 4'd1;
  localparam logic [3:0] S_WMUL  = 4'd2;
  localparam logic [3:0] S_ADD   = 4'd3;
  localparam logic [3:0] S_DINIT = 4'd4;
  localparam logic [3:0] S_DPOW  = 4'd5;
  localparam logic [3:0] S_DN    = 4'd6;
  localparam logic [3:0] S_DW    = 4'd7;
  localparam logic [3:0] S_DIVI  = 4'd8;
  localparam logic [3:0] S_DIV   = 4'd9;
  localparam logic [3:0] S_OINIT = 4'd10;
  localparam logic [3:0] S_OPOW  = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0]    state;
  logic [3:0]    state_next;
  logic [KW-1:0] k;
  logic [KW-1:0] k_next;
  logic [KW-1:0] k_inc;

  assign k_inc = k + KW'(1);

  always_comb begin
    state_next = state;
    k_next     = k;
    cmd.op     = OP_NONE;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = OP_LOAD;
          k_next = '0;
          state_next = (status.match_exp == 3'd0) ? S_WMUL : S_IPOW;
        end
      end
      S_IPOW: begin
        cmd.op = OP_IPOW;
        k_next = k_inc;
        if (k_inc == KW'(status.match_exp)) state_next = S_WMUL;
      end
      S_WMUL: begin
        cmd.op = OP_WMUL;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.op = OP_ADD;
        if (status.last) state_next = status.too_short ? S_OUT : S_DINIT;
        else state_next = S_IDLE;
      end
      S_DINIT: begin
        cmd.op = OP_DINIT;
        k_next = '0;
        state_next = (status.match_exp == 3'd0) ? S_DN : S_DPOW;
      end
      S_DPOW: begin
        cmd.op = OP_DPOW;
        k_next = k_inc;
        if (k_inc == KW'(status.match_exp)) state_next = S_DN;
      end
      S_DN: begin
        cmd.op = OP_DN;
        state_next = S_DW;
      end
      S_DW: begin
        cmd.op = OP_DW;
        state_next = S_DIVI;
      end
      S_DIVI: begin
        cmd.op = OP_DIVI;
        k_next = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.op = OP_DIV;
        k_next = k_inc;
        if (k_inc == KW'(STEPS)) state_next = S_OINIT;
      end
      S_OINIT: begin
        cmd.op = OP_OINIT;
        k_next = '0;
        state_next = (status.sum_exp == 3'd0) ? S_OUT : S_OPOW;
      end
      S_OPOW: begin
        cmd.op = OP_OPOW;
        k_next = k_inc;
        if (k_inc == KW'(status.sum_exp)) state_next = S_OUT;
      end
      S_OUT: begin
        if (status.slot_free) begin
          cmd.op = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k     <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
    end
  end

endmodule

// ----- rtl/locality_improved_string_kernel.sv -----
// locality_improved_string_kernel: top level of the streaming string kernel
// depends on lisk_pkg, lisk_ctrl, lisk_datapath
//
// Character pairs (char_a, char_b) come in on a valid/ready channel, one
// word per pair. After string_len pairs one result word (kernel_value,
// length_error) leaves on a valid/ready channel; other pairs give none.
// Registers are written through cfg_write/cfg_index/cfg_data; the user
// must write them only while idle, which the block does not enforce. A
// pair takes a load, match_exp multiplier steps for the match count
// power, a weight multiply and an accumulate; the next pair waits for
// them. The last pair then forms the divisor, runs the bit-serial divider
// (one step per quotient bit, 32 at 30 fraction bits) and the sum power
// before the output register is loaded; a too-short string skips these.
// The result sits in an output register, so the next string starts while
// the receiver stalls; only a second finished result waits for it.
// Reset is synchronous: registers return to their defaults, the window,
// position and sum clear and the output channel empties.
module locality_improved_string_kernel #(
  parameter int MAX_HALF_WINDOW = lisk_pkg::DEF_MAX_HALF_WINDOW,
  parameter int MAX_STRING_LEN  = lisk_pkg::DEF_MAX_STRING_LEN,
  parameter int FRAC_BITS       = lisk_pkg::DEF_FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       char_a,
  input  logic [7:0]                       char_b,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [31:0]                      kernel_value,
  output logic                             length_error,
  input  logic                             cfg_write,
  input  logic [lisk_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lisk_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import lisk_pkg::*;

  cmd_t    cmd;
  status_t status;

  lisk_ctrl #(
    .FRAC_BITS(FRAC_BITS)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .status  (status),
    .cmd     (cmd)
  );

  lisk_datapath #(
    .MAX_HALF_WINDOW(MAX_HALF_WINDOW),
    .MAX_STRING_LEN (MAX_STRING_LEN),
    .FRAC_BITS      (FRAC_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .char_a      (char_a),
    .char_b      (char_b),
    .cmd         (cmd),
    .status      (status),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .kernel_value(kernel_value),
    .length_error(length_error)
  );

endmodule
